// ===== hw/rtl/pppq_pkg.sv =====
// Shared types and constants for the per-port packet queue table.
package pppq_pkg;

    // Result status codes
    localparam logic [2:0] ST_ENQUEUED  = 3'd0;
    localparam logic [2:0] ST_BAD_LEN   = 3'd1;
    localparam logic [2:0] ST_DRY_RUN   = 3'd2;
    localparam logic [2:0] ST_DELIVERED = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    // Operation codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_DRY_RUN    = 1'b0;
    localparam logic CFG_PEER_ALIAS = 1'b1;

    localparam logic [15:0] MAX_LEN     = 16'd65507;
    localparam int          EVICT_W     = 7;
    localparam int          EVICT_MAX   = 127;
    localparam int          S_TDATA_W   = 144;
    localparam int          M_TDATA_W   = 88;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic pre;
        logic scan_clr;
        logic scan_issue;
        logic resolve;
        logic enq_adj;
        logic enq_wr;
        logic deq_rd;
        logic deq_wr;
        logic res_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic op_deq;
        logic pre_reject;
        logic scan_more;
        logic scan_end;
        logic deq_empty;
        logic out_busy;
    } stat_t;

endpackage

// ===== hw/rtl/per_port_packet_queue_table.sv =====
// Top level of the per-port packet queue table.
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid/s_tready    s_tuser = op, s_tdata = item fields
//  m_*       out        m_tvalid/m_tready    m_tuser = status, m_tdata = result
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An enqueue or dequeue that passes the length, dry-run and empty checks runs
// the port lookup, which reads the slot table RAM one slot per cycle through
// its registered read port and ends early on a match; then resolve, update and
// result load follow. Items rejected by the pre-checks skip the lookup and go
// straight to result load. Reset (aresetn low, synchronous) clears all slots,
// the queued count, the configuration registers, the controller state and the
// output valid flag; the descriptor RAM is not cleared. The result sits in an
// output register; while it waits on m_tready the following item holds in its
// last state, and s_tready stays low until the output register frees.
module per_port_packet_queue_table
    import pppq_pkg::*;
#(
    parameter int NUM_QUEUES  = 48,
    parameter int QUEUE_DEPTH = 64,
    parameter int HANDLE_BITS = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // port, src_ip, src_port, packet_length, payload_handle, buffer_length, now_ms
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // evicted_count, overflow_dropped, out_ip, out_port, copy_length, out_handle
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic [2:0]           m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data
);
    cmd_t  cmd;
    stat_t stat;

    // configuration writes are taken in any cycle
    assign cfg_ready = 1'b1;

    pppq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pppq_dp #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );
endmodule

// ===== hw/rtl/pppq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pppq_ram
    import pppq_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/pppq_ctrl.sv =====
// Sequencing state machine for the packet queue table.
module pppq_ctrl
    import pppq_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PRE      = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_RESOLVE  = 4'd3;
    localparam logic [3:0] S_ENQ_ADJ  = 4'd4;
    localparam logic [3:0] S_ENQ_WR   = 4'd5;
    localparam logic [3:0] S_DEQ_RD   = 4'd6;
    localparam logic [3:0] S_DEQ_WR   = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PRE;
                end
            end
            S_PRE: begin
                cmd.pre      = 1'b1;
                cmd.scan_clr = 1'b1;
                state_next   = stat.pre_reject ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_issue = stat.scan_more;
                if (stat.scan_end) begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                cmd.resolve = 1'b1;
                if (!stat.op_deq) begin
                    state_next = S_ENQ_ADJ;
                end else if (stat.deq_empty) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_DEQ_RD;
                end
            end
            S_ENQ_ADJ: begin
                cmd.enq_adj = 1'b1;
                state_next  = S_ENQ_WR;
            end
            S_ENQ_WR: begin
                cmd.enq_wr = 1'b1;
                state_next = S_DONE;
            end
            S_DEQ_RD: begin
                cmd.deq_rd = 1'b1;
                state_next = S_DEQ_WR;
            end
            S_DEQ_WR: begin
                cmd.deq_wr = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!stat.out_busy) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== hw/rtl/pppq_dp.sv =====
// Datapath: slot table, descriptor store, lookup scan and result registers.
module pppq_dp
    import pppq_pkg::*;
#(
    parameter int NUM_QUEUES  = 48,
    parameter int QUEUE_DEPTH = 64,
    parameter int HANDLE_BITS = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  logic                 in_op,
    input  logic [S_TDATA_W-1:0] in_data,
    input  logic                 cfg_we,
    input  logic                 cfg_idx,
    input  logic [31:0]          cfg_wdata,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [2:0]           m_tuser
);
    localparam int SW   = NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1;
    localparam int IW   = $clog2(NUM_QUEUES + 1);
    localparam int HW   = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int OW   = CW + 1;
    localparam int DD   = NUM_QUEUES * QUEUE_DEPTH;
    localparam int DAW  = DD > 1 ? $clog2(DD) : 1;
    localparam int TW   = $clog2(DD + 1);
    localparam int SLW  = 16 + 32 + HW + CW;
    localparam int DSW  = 32 + 16 + 16 + HANDLE_BITS;

    // captured item
    logic        op_reg;
    logic [15:0] port_reg, sport_reg, plen_reg, blen_reg;
    logic [31:0] sip_reg, now_reg;
    logic [11:0] hnd_reg;

    // configuration
    logic        dry_run_reg;
    logic [31:0] alias_reg;

    // slot table
    logic [NUM_QUEUES-1:0] used_reg;
    logic [TW-1:0]         total_reg;
    logic                  slot_we;
    logic [SW-1:0]         slot_waddr;
    logic [SLW-1:0]        slot_wdata, slot_rdata;

    // scan
    logic [IW-1:0] issue_idx_reg;
    logic          cmp_valid_reg;
    logic [SW-1:0] cmp_idx_reg;
    logic          hit_reg, free_found_reg;
    logic [SW-1:0] hit_idx_reg, free_idx_reg, lru_idx_reg;
    logic [HW-1:0] hit_head_reg, lru_head_reg;
    logic [CW-1:0] hit_cnt_reg, lru_cnt_reg;
    logic [31:0]   lru_time_reg;

    // selected slot
    logic [SW-1:0] sel_slot_reg;
    logic [HW-1:0] sel_head_reg;
    logic [CW-1:0] sel_cnt_reg;
    logic          sel_evict_reg;

    // descriptor store
    logic           desc_we;
    logic [DAW-1:0] desc_waddr, desc_raddr, desc_base;
    logic [DSW-1:0] desc_wdata, desc_rdata;

    // staged and output result
    logic [2:0]         st_status_reg;
    logic [EVICT_W-1:0] st_evicted_reg;
    logic               st_ovf_reg;
    logic [31:0]        st_ip_reg;
    logic [15:0]        st_port_reg, st_clen_reg;
    logic [11:0]        st_hnd_reg;
    logic               m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [2:0]         m_user_reg;

    // compare stage view of a slot record; an unused slot reads as zero
    logic          rec_used;
    logic [15:0]   rec_port;
    logic [31:0]   rec_time;
    logic [HW-1:0] rec_head;
    logic [CW-1:0] rec_cnt;
    logic          rec_match;

    always_comb begin
        rec_used = used_reg[cmp_idx_reg];
        {rec_port, rec_time, rec_head, rec_cnt} = rec_used ? slot_rdata : '0;
        rec_match = rec_used && (rec_port == port_reg);
    end

    // pre-check outcome
    logic       pre_reject;
    logic [2:0] pre_code;
    always_comb begin
        pre_reject = 1'b0;
        pre_code   = ST_EMPTY;
        if (op_reg == OP_ENQUEUE) begin
            if (plen_reg == 16'd0 || plen_reg > MAX_LEN) begin
                pre_reject = 1'b1;
                pre_code   = ST_BAD_LEN;
            end else if (dry_run_reg) begin
                pre_reject = 1'b1;
                pre_code   = ST_DRY_RUN;
            end
        end else if (port_reg == 16'd0 || total_reg == '0) begin
            pre_reject = 1'b1;
        end
    end

    // enqueue adjustment
    logic [CW-1:0] adj_cnt0;
    logic          adj_full;
    logic [HW:0]   head_inc;
    logic [HW-1:0] head_wrap;
    logic [OW-1:0] tail_sum;
    logic [HW-1:0] tail_wrap;
    always_comb begin
        adj_cnt0  = sel_evict_reg ? '0 : sel_cnt_reg;
        adj_full  = adj_cnt0 >= CW'(QUEUE_DEPTH);
        head_inc  = (HW+1)'(sel_head_reg) + (HW+1)'(1);
        head_wrap = (head_inc >= (HW+1)'(QUEUE_DEPTH)) ? '0 : HW'(head_inc);
        tail_sum  = OW'(sel_head_reg) + OW'(sel_cnt_reg);
        tail_wrap = (tail_sum >= OW'(QUEUE_DEPTH)) ? HW'(tail_sum - OW'(QUEUE_DEPTH))
                                                   : HW'(tail_sum);
        desc_base = DAW'(sel_slot_reg) * DAW'(QUEUE_DEPTH);
    end

    // descriptor fields
    logic [31:0]          d_ip;
    logic [15:0]          d_sport, d_plen;
    logic [HANDLE_BITS-1:0] d_hnd;
    assign {d_ip, d_sport, d_plen, d_hnd} = desc_rdata;

    assign desc_we    = cmd.enq_wr;
    assign desc_waddr = desc_base + DAW'(tail_wrap);
    assign desc_wdata = {sip_reg, sport_reg, plen_reg, HANDLE_BITS'(hnd_reg)};
    assign desc_raddr = desc_base + DAW'(sel_head_reg);

    assign slot_we    = cmd.enq_wr || cmd.deq_wr;
    assign slot_waddr = sel_slot_reg;
    assign slot_wdata = cmd.enq_wr ? {port_reg, now_reg, sel_head_reg, sel_cnt_reg + CW'(1)}
                                   : {port_reg, now_reg, head_wrap, sel_cnt_reg - CW'(1)};

    pppq_ram #(.WIDTH(SLW), .DEPTH(NUM_QUEUES)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (issue_idx_reg[SW-1:0]),
        .rdata (slot_rdata)
    );

    pppq_ram #(.WIDTH(DSW), .DEPTH(DD)) u_desc_ram (
        .aclk  (aclk),
        .we    (desc_we),
        .waddr (desc_waddr),
        .wdata (desc_wdata),
        .raddr (desc_raddr),
        .rdata (desc_rdata)
    );

    always_comb begin
        stat.op_deq     = op_reg;
        stat.pre_reject = pre_reject;
        stat.scan_more  = issue_idx_reg < IW'(NUM_QUEUES);
        stat.scan_end   = cmp_valid_reg && (rec_match || cmp_idx_reg == SW'(NUM_QUEUES - 1));
        stat.deq_empty  = !hit_reg || hit_cnt_reg == '0;
        stat.out_busy   = m_valid_reg && !m_tready;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            total_reg     <= '0;
            dry_run_reg   <= 1'b0;
            alias_reg     <= '0;
            m_valid_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    CFG_DRY_RUN:    dry_run_reg <= cfg_wdata[0];
                    CFG_PEER_ALIAS: alias_reg   <= cfg_wdata;
                    default:        dry_run_reg <= dry_run_reg;
                endcase
            end
            cmp_valid_reg <= cmd.scan_issue;
            if (cmd.enq_adj) begin
                total_reg <= total_reg - (sel_evict_reg ? TW'(sel_cnt_reg) : '0)
                                       - (adj_full ? TW'(1) : '0);
            end
            if (cmd.enq_wr) begin
                used_reg[sel_slot_reg] <= 1'b1;
                total_reg              <= total_reg + TW'(1);
            end
            if (cmd.deq_wr) begin
                total_reg <= total_reg - TW'(1);
            end
            if (cmd.res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= in_op;
            port_reg  <= in_data[15:0];
            sip_reg   <= in_data[47:16];
            sport_reg <= in_data[63:48];
            plen_reg  <= in_data[79:64];
            hnd_reg   <= in_data[91:80];
            blen_reg  <= in_data[107:92];
            now_reg   <= in_data[139:108];
            st_status_reg  <= in_op ? ST_EMPTY : ST_ENQUEUED;
            st_evicted_reg <= '0;
            st_ovf_reg     <= 1'b0;
            st_ip_reg      <= '0;
            st_port_reg    <= '0;
            st_clen_reg    <= '0;
            st_hnd_reg     <= '0;
        end
        if (cmd.pre && pre_reject) begin
            st_status_reg <= pre_code;
        end
        if (cmd.scan_clr) begin
            issue_idx_reg  <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        if (cmd.scan_issue) begin
            issue_idx_reg <= issue_idx_reg + IW'(1);
            cmp_idx_reg   <= issue_idx_reg[SW-1:0];
        end
        if (cmp_valid_reg) begin
            if (rec_match && !hit_reg) begin
                hit_reg      <= 1'b1;
                hit_idx_reg  <= cmp_idx_reg;
                hit_head_reg <= rec_head;
                hit_cnt_reg  <= rec_cnt;
            end
            if (!rec_used && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= cmp_idx_reg;
            end
            if (cmp_idx_reg == '0 || rec_time < lru_time_reg) begin
                lru_idx_reg  <= cmp_idx_reg;
                lru_time_reg <= rec_time;
                lru_head_reg <= rec_head;
                lru_cnt_reg  <= rec_cnt;
            end
        end
        if (cmd.resolve) begin
            priority if (hit_reg) begin
                sel_slot_reg  <= hit_idx_reg;
                sel_head_reg  <= hit_head_reg;
                sel_cnt_reg   <= hit_cnt_reg;
                sel_evict_reg <= 1'b0;
            end else if (free_found_reg) begin
                sel_slot_reg  <= free_idx_reg;
                sel_head_reg  <= '0;
                sel_cnt_reg   <= '0;
                sel_evict_reg <= 1'b0;
            end else begin
                sel_slot_reg  <= lru_idx_reg;
                sel_head_reg  <= lru_head_reg;
                sel_cnt_reg   <= lru_cnt_reg;
                sel_evict_reg <= 1'b1;
            end
        end
        if (cmd.enq_adj) begin
            if (sel_evict_reg) begin
                st_evicted_reg <= (32'(sel_cnt_reg) > 32'(EVICT_MAX)) ? EVICT_W'(EVICT_MAX)
                                                                     : EVICT_W'(sel_cnt_reg);
            end
            if (adj_full) begin
                sel_head_reg <= head_wrap;
                sel_cnt_reg  <= adj_cnt0 - CW'(1);
                st_ovf_reg   <= 1'b1;
            end else begin
                sel_cnt_reg  <= adj_cnt0;
            end
        end
        if (cmd.deq_wr) begin
            st_status_reg <= ST_DELIVERED;
            st_ip_reg     <= (alias_reg != '0) ? alias_reg : d_ip;
            st_port_reg   <= d_sport;
            st_clen_reg   <= (d_plen > blen_reg) ? blen_reg : d_plen;
            st_hnd_reg    <= 12'(d_hnd);
        end
        if (cmd.res_load) begin
            m_user_reg <= st_status_reg;
            m_data_reg <= {4'd0, st_hnd_reg, st_clen_reg, st_port_reg, st_ip_reg,
                           st_ovf_reg, st_evicted_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
endmodule

// ===== hw/rtl/pppq_checker.sv =====
// Port-level checks for the packet queue table, bound to the top level.
module pppq_checker
    import pppq_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [2:0]           m_tuser
);
    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_ENQUEUED || m_tuser == ST_BAD_LEN ||
                      m_tuser == ST_DRY_RUN || m_tuser == ST_DELIVERED ||
                      m_tuser == ST_EMPTY))
        else $error("bad status code");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_DELIVERED |-> m_tdata[83:8] == '0)
        else $error("delivery fields set on non-delivery result");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while busy");
endmodule

bind per_port_packet_queue_table pppq_checker u_pppq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== verif/tb_per_port_packet_queue_table.sv =====
// Self-checking testbench for the per-port packet queue table.
module tb_per_port_packet_queue_table
    import pppq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NQ = 48;
    localparam int QD = 64;
    localparam int WATCHDOG_LIMIT = 200000;

    // One packet event as sent on the input stream
    typedef struct {
        logic        op;
        logic [15:0] port;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [15:0] pkt_len;
        logic [11:0] handle;
        logic [15:0] buf_len;
        logic [31:0] now_ms;
    } pkt_event_t;

    // One result beat
    typedef struct {
        logic [2:0]  status;
        logic [6:0]  evicted;
        logic        ovf;
        logic [31:0] ip;
        logic [15:0] port;
        logic [15:0] copy_len;
        logic [11:0] handle;
    } queue_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [2:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;
    logic [31:0] tick = 0;

    always #5 aclk = ~aclk;

    per_port_packet_queue_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Mirror of the queue table; predicts one result per accepted event
    class queue_scoreboard;
        bit          used[NQ];
        logic [15:0] sport[NQ];
        logic [31:0] last_used[NQ];
        int          head[NQ];
        int          count[NQ];
        logic [31:0] d_ip[NQ*QD];
        logic [15:0] d_port[NQ*QD];
        logic [15:0] d_len[NQ*QD];
        logic [11:0] d_hnd[NQ*QD];
        int          total;
        logic        dry_run;
        logic [31:0] alias_ip;
        queue_result_t pending[$];

        function void clear();
            foreach (used[i]) begin
                used[i] = 0; sport[i] = 0; last_used[i] = 0; head[i] = 0; count[i] = 0;
            end
            total = 0; dry_run = 0; alias_ip = 0;
        endfunction

        function int find_port(input logic [15:0] p, output int free_s, output int lru_s);
            free_s = -1;
            lru_s = 0;
            for (int i = 0; i < NQ; i++) begin
                if (used[i] && sport[i] == p) return i;
                if (!used[i] && free_s < 0) free_s = i;
                if (last_used[i] < last_used[lru_s]) lru_s = i;
            end
            return -1;
        endfunction

        function void note_event(input pkt_event_t e);
            queue_result_t r;
            int s, f, o, pos;
            r = '{default: '0};
            if (e.op == OP_ENQUEUE) begin
                if (e.pkt_len == 0 || e.pkt_len > MAX_LEN) r.status = ST_BAD_LEN;
                else if (dry_run) r.status = ST_DRY_RUN;
                else begin
                    s = find_port(e.port, f, o);
                    if (s < 0) begin
                        if (f >= 0) s = f;
                        else begin
                            s = o;
                            r.evicted = 7'((count[s] > EVICT_MAX) ? EVICT_MAX : count[s]);
                            total -= count[s];
                            count[s] = 0;
                        end
                        used[s] = 1;
                        sport[s] = e.port;
                    end
                    last_used[s] = e.now_ms;
                    if (count[s] >= QD) begin
                        head[s] = (head[s] + 1) % QD;
                        count[s]--; total--;
                        r.ovf = 1;
                    end
                    pos = s * QD + (head[s] + count[s]) % QD;
                    d_ip[pos] = e.src_ip; d_port[pos] = e.src_port;
                    d_len[pos] = e.pkt_len; d_hnd[pos] = e.handle;
                    count[s]++; total++;
                    r.status = ST_ENQUEUED;
                end
            end else begin
                r.status = ST_EMPTY;
                if (e.port != 0 && total != 0) begin
                    s = find_port(e.port, f, o);
                    if (s >= 0 && count[s] != 0) begin
                        pos = s * QD + head[s];
                        r.port = d_port[pos];
                        r.copy_len = (d_len[pos] > e.buf_len) ? e.buf_len : d_len[pos];
                        r.handle = d_hnd[pos];
                        r.ip = (alias_ip != 0) ? alias_ip : d_ip[pos];
                        head[s] = (head[s] + 1) % QD;
                        count[s]--; total--;
                        last_used[s] = e.now_ms;
                        r.status = ST_DELIVERED;
                    end
                end
            end
            pending = {pending, r};
        endfunction

        task check_result(input logic [2:0] st, input logic [M_TDATA_W-1:0] d);
            queue_result_t w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result, status", 32'(st), 32'd0);
                return;
            end
            w = pending[0];
            pending.delete(0);
            if (st !== w.status) report_mismatch("status", 32'(st), 32'(w.status));
            if (d[6:0] !== w.evicted)
                report_mismatch("evicted_count", 32'(d[6:0]), 32'(w.evicted));
            if (d[7] !== w.ovf) report_mismatch("overflow_dropped", 32'(d[7]), 32'(w.ovf));
            if (d[39:8] !== w.ip) report_mismatch("out_ip", d[39:8], w.ip);
            if (d[55:40] !== w.port)
                report_mismatch("out_port", 32'(d[55:40]), 32'(w.port));
            if (d[71:56] !== w.copy_len)
                report_mismatch("copy_length", 32'(d[71:56]), 32'(w.copy_len));
            if (d[83:72] !== w.handle)
                report_mismatch("out_handle", 32'(d[83:72]), 32'(w.handle));
        endtask
    endclass

    queue_scoreboard sb = new();

    // Receiver: random stall, check each beat taken
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles where nothing moves
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Advance the clock first so tvalid is never dropped and raised in one step
    task automatic send_event(input pkt_event_t e);
        do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        s_tvalid <= 1'b1;
        s_tuser <= e.op;
        s_tdata <= {4'b0, e.now_ms, e.buf_len, e.handle, e.pkt_len, e.src_port,
                    e.src_ip, e.port};
        do @(posedge aclk); while (!s_tready);
        sb.note_event(e);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (NQ + 20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_DRY_RUN) sb.dry_run = val[0];
        else sb.alias_ip = val;
    endtask

    function automatic pkt_event_t make_event(input logic op, input logic [15:0] port,
                                              input logic [15:0] len);
        pkt_event_t e;
        e.op = op; e.port = port; e.pkt_len = len;
        e.src_ip = $urandom; e.src_port = 16'($urandom); e.handle = 12'($urandom);
        e.buf_len = 16'($urandom);
        tick = tick + $urandom_range(3);
        e.now_ms = tick;
        return e;
    endfunction

    // Random event: ports from a pool bigger than the table so eviction happens
    task automatic random_event();
        pkt_event_t e;
        int k;
        k = $urandom_range(99);
        e = make_event($urandom_range(99) < 45 ? OP_DEQUEUE : OP_ENQUEUE,
                       (k < 3) ? 16'($urandom) : 16'($urandom_range(60)),
                       16'($urandom_range(1, 2000)));
        if (k < 5) e.pkt_len = (k < 2) ? 16'd0 : 16'($urandom_range(65508, 65535));
        else if (k < 8) e.pkt_len = 16'($urandom_range(1, 65507));
        if ($urandom_range(9) == 0) e.buf_len = 16'($urandom_range(16));
        if ($urandom_range(19) == 0) e.now_ms = $urandom;
        send_event(e);
    endtask

    initial begin
        pkt_event_t e;
        sb.clear();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, length limits, dry run, alias, overflow, eviction
        send_event(make_event(OP_DEQUEUE, 16'd5, 16'd1));
        send_event(make_event(OP_ENQUEUE, 16'd5, 16'd0));
        send_event(make_event(OP_ENQUEUE, 16'd5, 16'd65508));
        send_event(make_event(OP_ENQUEUE, 16'd5, 16'hFFFF));
        send_event(make_event(OP_ENQUEUE, 16'd5, MAX_LEN));
        send_event(make_event(OP_ENQUEUE, 16'd0, 16'd1));
        e = make_event(OP_ENQUEUE, 16'hFFFF, 16'd100);
        e.src_ip = '1; e.src_port = '1; e.handle = '1;
        send_event(e);
        send_event(make_event(OP_DEQUEUE, 16'd0, 16'd1));
        send_event(make_event(OP_DEQUEUE, 16'd77, 16'd1));
        e = make_event(OP_DEQUEUE, 16'd5, 16'd1); e.buf_len = 16'd0; send_event(e);
        e = make_event(OP_DEQUEUE, 16'hFFFF, 16'd1); e.buf_len = '1; send_event(e);
        send_event(make_event(OP_DEQUEUE, 16'hFFFF, 16'd1));
        write_reg(CFG_DRY_RUN, 32'd1);
        send_event(make_event(OP_ENQUEUE, 16'd9, 16'd10));
        send_event(make_event(OP_ENQUEUE, 16'd9, 16'd0));
        write_reg(CFG_DRY_RUN, 32'd0);
        write_reg(CFG_PEER_ALIAS, 32'hFFFF_FFFF);
        send_event(make_event(OP_ENQUEUE, 16'd9, 16'd10));
        send_event(make_event(OP_DEQUEUE, 16'd9, 16'd1));
        write_reg(CFG_PEER_ALIAS, 32'd0);
        // Overfill one queue, then fill every slot so the next port evicts
        for (int i = 0; i < QD + 3; i++) send_event(make_event(OP_ENQUEUE, 16'd3, 16'd7));
        for (int p = 100; p < 100 + NQ; p++) send_event(make_event(OP_ENQUEUE, 16'(p), 16'd7));
        e = make_event(OP_ENQUEUE, 16'd200, 16'd7); e.now_ms = tick + 5; send_event(e);

        // Random phases with different idling, alias and dry-run settings
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 79 : 0;
            recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 37 : 0;
            write_reg(CFG_PEER_ALIAS, (ph == 1) ? $urandom : 32'd0);
            for (int n = 0; n < 570; n++) begin
                if (n == 300) drain();
                random_event();
            end
            write_reg(CFG_DRY_RUN, 32'd1);
            for (int n = 0; n < 20; n++) random_event();
            write_reg(CFG_DRY_RUN, 32'd0);
        end

        drain();
        if (errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
